@@ sv/pngunf_pkg.sv @@
// shared types and codes for the png scanline unfilter
package pngunf_pkg;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic CFG_BPP     = 1'b0;
    localparam logic CFG_ROW_LEN = 1'b1;

    localparam int BPP_W     = 4;
    localparam int ROW_LEN_W = 13;
    localparam int CFG_W     = 13;

    typedef struct packed {
        logic       is_error;
        logic [2:0] filter;
        logic       top_line;
        logic       row_first;
        logic       row_end;
        logic [7:0] data;
    } item_t;

endpackage

@@ sv/png_scanline_unfilter_core.sv @@
// top level of the png scanline unfilter
// usage:
//   s_ channel takes one inflated byte per beat: s_tdata is the byte,
//   s_tuser[0] marks the first byte of a new image. each row is one filter
//   type byte followed by row_length data bytes.
//   m_ channel gives one rebuilt byte per data byte: m_tdata is the byte,
//   m_tlast marks the last byte of a row, m_tuser[0] flags a bad filter type
//   (one error beat, then input is swallowed until the next image start).
//   valid filter type bytes give no output beat.
//   cfg_wr_en/cfg_addr/cfg_wdata set pixel stride (0) and row length (1) when idle.
// timing:
//   one byte per clock while m_tready holds no stall; an output beat goes from
//   the queue write through the above row memory read and the predictor into
//   the output register; the left neighbour feedback runs through a register.
// reset: control state clears at once, no clearing pass; the above row
//   memory is undefined until a first row has written it.
// backpressure:
//   a 4-entry queue plus the memory stage and output register absorb an
//   m_tready stall; s_tready drops only when the queue fills.
module png_scanline_unfilter_core #(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic [0:0]                       s_tuser,   // [0] image_start
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] pixel_byte
    output logic                             m_tlast,
    output logic [0:0]                       m_tuser,   // [0] filter_error
    input  logic                             cfg_wr_en,
    input  logic                             cfg_addr,
    input  logic [pngunf_pkg::CFG_W-1:0]     cfg_wdata
);
    import pngunf_pkg::*;

    localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int IDX_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int BSEL_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [BPP_W-1:0]     bpp_reg;
    logic [ROW_LEN_W-1:0] row_len_reg;
    logic [BPP_W-1:0]     bpp_m1;
    logic [BSEL_W-1:0]    bpp_sel;
    logic [POS_W-1:0]     row_len_c;

    logic                 q_full, push, head_valid, pop;
    item_t                push_item, head_item;
    logic [IDX_W-1:0]     push_idx, head_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg     <= BPP_W'(1);
            row_len_reg <= ROW_LEN_W'(1);
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_BPP) begin
                bpp_reg <= cfg_wdata[BPP_W-1:0];
            end else begin
                row_len_reg <= cfg_wdata[ROW_LEN_W-1:0];
            end
        end
    end

    assign bpp_m1 = bpp_reg - BPP_W'(1);

    always_comb begin
        if (bpp_reg == '0) begin
            bpp_sel = '0;
        end else if (32'(bpp_reg) > 32'(MAX_PIXEL_BYTES)) begin
            bpp_sel = BSEL_W'(MAX_PIXEL_BYTES - 1);
        end else begin
            bpp_sel = bpp_m1[BSEL_W-1:0];
        end
        if (row_len_reg == '0) begin
            row_len_c = POS_W'(1);
        end else if (32'(row_len_reg) > 32'(MAX_ROW_BYTES)) begin
            row_len_c = POS_W'(MAX_ROW_BYTES);
        end else begin
            row_len_c = POS_W'(row_len_reg);
        end
    end

    pngunf_front #(
        .POS_W (POS_W),
        .IDX_W (IDX_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_data        (s_tdata),
        .in_image_start (s_tuser[0]),
        .row_len        (row_len_c),
        .q_full         (q_full),
        .in_ready       (s_tready),
        .push           (push),
        .push_item      (push_item),
        .push_idx       (push_idx)
    );

    pngunf_queue #(
        .IDX_W (IDX_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .push_idx   (push_idx),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_idx   (head_idx),
        .pop        (pop)
    );

    pngunf_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .IDX_W           (IDX_W),
        .BSEL_W          (BSEL_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .bpp_sel     (bpp_sel),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .head_idx    (head_idx),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pixel   (m_tdata),
        .out_row_end (m_tlast),
        .out_error   (m_tuser[0])
    );

endmodule

@@ sv/pngunf_front.sv @@
// front end: row position tracking and byte classification
module pngunf_front #(
    parameter int POS_W = 13,
    parameter int IDX_W = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           in_data,
    input  logic                 in_image_start,
    input  logic [POS_W-1:0]     row_len,
    input  logic                 q_full,
    output logic                 in_ready,
    output logic                 push,
    output pngunf_pkg::item_t    push_item,
    output logic [IDX_W-1:0]     push_idx
);
    import pngunf_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_eff, pos_m1;
    logic [2:0]       filt_reg, filt_next;
    logic             top_line_reg, top_line_next, first_eff;
    logic             lock_reg, lock_next, lock_eff;
    logic             accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign pos_eff  = in_image_start ? '0 : pos_reg;
    assign first_eff = in_image_start | top_line_reg;
    assign lock_eff = !in_image_start && lock_reg;
    assign pos_m1   = pos_eff - POS_W'(1);
    assign push_idx = pos_m1[IDX_W-1:0];

    always_comb begin
        pos_next       = pos_reg;
        filt_next      = filt_reg;
        top_line_next  = top_line_reg;
        lock_next      = lock_reg;
        push           = 1'b0;
        push_item.is_error  = 1'b0;
        push_item.filter    = filt_reg;
        push_item.top_line  = first_eff;
        push_item.row_first = (pos_eff == POS_W'(1));
        push_item.row_end   = (pos_eff >= row_len);
        push_item.data      = in_data;
        if (accept) begin
            pos_next       = pos_eff;
            top_line_next  = first_eff;
            lock_next      = lock_eff;
            if (!lock_eff) begin
                if (pos_eff == '0) begin
                    if (in_data > {5'd0, FILT_PAETH}) begin
                        lock_next          = 1'b1;
                        push               = 1'b1;
                        push_item.is_error = 1'b1;
                    end else begin
                        filt_next = in_data[2:0];
                        pos_next  = POS_W'(1);
                    end
                end else begin
                    push = 1'b1;
                    if (pos_eff >= row_len) begin
                        pos_next      = '0;
                        top_line_next = 1'b0;
                    end else begin
                        pos_next = pos_eff + POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            filt_reg     <= FILT_NONE;
            top_line_reg <= 1'b1;
            lock_reg     <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            filt_reg     <= filt_next;
            top_line_reg <= top_line_next;
            lock_reg     <= lock_next;
        end
    end

endmodule

@@ sv/pngunf_queue.sv @@
// short queue between front and back end
module pngunf_queue #(
    parameter int IDX_W = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  pngunf_pkg::item_t    push_item,
    input  logic [IDX_W-1:0]     push_idx,
    output logic                 full,
    output logic                 head_valid,
    output pngunf_pkg::item_t    head_item,
    output logic [IDX_W-1:0]     head_idx,
    input  logic                 pop
);
    import pngunf_pkg::*;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = 2;
    localparam int CNT_W  = 3;

    item_t            item_mem [QDEPTH];
    logic [IDX_W-1:0] idx_mem  [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = item_mem[rd_ptr_reg];
    assign head_idx   = idx_mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_mem[wr_ptr_reg] <= push_item;
            idx_mem[wr_ptr_reg]  <= push_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/pngunf_back.sv @@
// back end: above row memory, predictors and output register
module pngunf_back #(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 8,
    parameter int IDX_W           = 12,
    parameter int BSEL_W          = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [BSEL_W-1:0]    bpp_sel,
    input  logic                 head_valid,
    input  pngunf_pkg::item_t    head_item,
    input  logic [IDX_W-1:0]     head_idx,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_pixel,
    output logic                 out_row_end,
    output logic                 out_error
);
    import pngunf_pkg::*;

    logic [7:0]       above_mem [MAX_ROW_BYTES];
    logic [7:0]       mem_q_reg;
    logic             fwd_reg;
    logic [7:0]       fwd_data_reg;

    logic             s1_valid_reg;
    item_t            s1_item_reg;
    logic [IDX_W-1:0] s1_idx_reg;

    logic [7:0]       raw_hist_reg   [MAX_PIXEL_BYTES];
    logic [7:0]       above_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0]       raw_base       [MAX_PIXEL_BYTES];
    logic [7:0]       above_base     [MAX_PIXEL_BYTES];

    logic             out_valid_reg;
    logic [7:0]       out_pixel_reg;
    logic             out_row_end_reg;
    logic             out_error_reg;

    logic             out_adv, s1_load, mem_we;
    logic [7:0]       a, b, c, pred, v;
    logic [8:0]       sum_ab;
    logic signed [10:0] pa, pb, pc;

    assign out_adv = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_load = head_valid && (!s1_valid_reg || out_adv);
    assign pop     = s1_load;
    assign mem_we  = out_adv && !s1_item_reg.is_error;

    always_comb begin
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            raw_base[k]   = s1_item_reg.row_first ? 8'd0 : raw_hist_reg[k];
            above_base[k] = s1_item_reg.row_first ? 8'd0 : above_hist_reg[k];
        end
    end

    assign a = raw_base[bpp_sel];
    assign c = above_base[bpp_sel];
    assign b = s1_item_reg.top_line ? 8'd0 : (fwd_reg ? fwd_data_reg : mem_q_reg);
    assign sum_ab = {1'b0, a} + {1'b0, b};

    assign pa = ($signed({3'b0, b}) >= $signed({3'b0, c})) ?
                $signed({3'b0, b}) - $signed({3'b0, c}) :
                $signed({3'b0, c}) - $signed({3'b0, b});
    assign pb = ($signed({3'b0, a}) >= $signed({3'b0, c})) ?
                $signed({3'b0, a}) - $signed({3'b0, c}) :
                $signed({3'b0, c}) - $signed({3'b0, a});
    assign pc = ($signed({2'b0, sum_ab}) >= $signed({2'b0, c, 1'b0})) ?
                $signed({2'b0, sum_ab}) - $signed({2'b0, c, 1'b0}) :
                $signed({2'b0, c, 1'b0}) - $signed({2'b0, sum_ab});

    always_comb begin
        case (s1_item_reg.filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH: begin
                if (pa <= pb && pa <= pc) begin
                    pred = a;
                end else if (pb <= pc) begin
                    pred = b;
                end else begin
                    pred = c;
                end
            end
            default:    pred = 8'd0;
        endcase
    end

    assign v = s1_item_reg.data + pred;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            above_mem[s1_idx_reg] <= v;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            mem_q_reg    <= above_mem[head_idx];
            fwd_reg      <= mem_we && (s1_idx_reg == head_idx);
            fwd_data_reg <= v;
            s1_item_reg  <= head_item;
            s1_idx_reg   <= head_idx;
        end
        if (out_adv) begin
            out_pixel_reg   <= s1_item_reg.is_error ? 8'd0 : v;
            out_row_end_reg <= !s1_item_reg.is_error && s1_item_reg.row_end;
            out_error_reg   <= s1_item_reg.is_error;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                raw_hist_reg[k]   <= 8'd0;
                above_hist_reg[k] <= 8'd0;
            end
        end else begin
            if (s1_load) begin
                s1_valid_reg <= 1'b1;
            end else if (out_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (out_adv) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (mem_we) begin
                raw_hist_reg[0]   <= v;
                above_hist_reg[0] <= b;
                for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
                    raw_hist_reg[k]   <= raw_base[k-1];
                    above_hist_reg[k] <= above_base[k-1];
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_pixel   = out_pixel_reg;
    assign out_row_end = out_row_end_reg;
    assign out_error   = out_error_reg;

endmodule

@@ sv/pngunf_checker.sv @@
// port level checks for the png scanline unfilter, with bind
module pngunf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    a_error_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'd0 && !m_tlast)
        else $error("error beat carries data or row end");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind png_scanline_unfilter_core pngunf_checker u_pngunf_checker (.*);
